FILE: hw/rtl/chsv_pkg.sv
// Package for the color HSV classifier: request and result types, pipeline stage types,
// constants and the one-bit divider step function.
// No dependencies.
package chsv_pkg;

    // Request and result payloads.
    typedef struct packed {
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
        logic [15:0] clear_count;
    } in_t;

    typedef struct packed {
        logic [15:0] red_norm;
        logic [15:0] green_norm;
        logic [15:0] blue_norm;
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
        logic [16:0] lux;
        logic [1:0]  color_class;
    } out_t;

    // Class codes.
    localparam logic [1:0] CLASS_BLACK = 2'd0;
    localparam logic [1:0] CLASS_RED   = 2'd1;
    localparam logic [1:0] CLASS_BLUE  = 2'd2;

    // Which channel holds the maximum.
    localparam logic [1:0] MAX_RED   = 2'd0;
    localparam logic [1:0] MAX_GREEN = 2'd1;
    localparam logic [1:0] MAX_BLUE  = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_BLUE_SAT_MAX  = 2'd0;
    localparam logic [1:0] REG_BLUE_VAL_MAX  = 2'd1;
    localparam logic [1:0] REG_BLACK_VAL_MAX = 2'd2;

    localparam logic [15:0] BLUE_SAT_MAX_RST  = 16'd19661;
    localparam logic [15:0] BLUE_VAL_MAX_RST  = 16'd6881;
    localparam logic [15:0] BLACK_VAL_MAX_RST = 16'd9830;

    // Lux coefficients, Q.16.
    localparam logic [32:0] LUX_KG = 33'd103440;
    localparam logic [30:0] LUX_KR = 31'd21277;
    localparam logic [31:0] LUX_KB = 32'd47966;

    localparam logic [29:0] DIM_SCALE   = 30'd10000;
    localparam logic [28:0] HUE_SIXTH29 = 29'd3840;
    localparam logic [14:0] HUE_SIXTH   = 15'd3840;
    localparam logic [14:0] HUE_GREEN   = 15'd3840;
    localparam logic [14:0] HUE_BLUE    = 15'd11520;
    localparam logic [14:0] HUE_WRAP    = 15'd19200;

    // Divider lanes.
    localparam int NLANE     = 6;
    localparam int LANE_R    = 0;
    localparam int LANE_G    = 1;
    localparam int LANE_B    = 2;
    localparam int LANE_VAL  = 3;
    localparam int LANE_SAT  = 4;
    localparam int LANE_HUE  = 5;
    localparam int NDIV      = 8;   // divider stages, two quotient bits each

    // One lane of a restoring divider: partial remainder, unshifted numerator
    // bits and quotient so far.
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] lo;
        logic [15:0] quo;
    } lane_t;

    // First stage: registered counts, maximum, spread, hue numerator and lux products.
    typedef struct packed {
        logic [15:0] c;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] mx;
        logic [15:0] d;
        logic [16:0] nd;
        logic [1:0]  ksel;
        logic [32:0] pg;
        logic [30:0] pr;
        logic [31:0] pb;
    } s1_t;

    // Divider stages.
    typedef struct packed {
        logic [15:0] c;
        logic [15:0] mx;
        logic [15:0] d;
        lane_t [NLANE-1:0] lane;
        logic [4:0]  ovf;
        logic        hue_ok;
        logic [1:0]  ksel;
        logic [16:0] lux;
    } div_t;

    // One restoring division step.
    function automatic lane_t div_step(lane_t x, logic [15:0] dv);
        logic [16:0] t;
        lane_t y;
        t = {x.rem, x.lo[15]};
        y.lo = {x.lo[14:0], 1'b0};
        if (t >= {1'b0, dv})
        begin
            y.rem = 16'(t - {1'b0, dv});
            y.quo = {x.quo[14:0], 1'b1};
        end
        else
        begin
            y.rem = t[15:0];
            y.quo = {x.quo[14:0], 1'b0};
        end
        return y;
    endfunction

endpackage

FILE: hw/rtl/color_hsv_classifier.sv
// Color HSV classifier top level: pipelined normalization, HSV, lux and class.
// Depends on chsv_pkg.
//
// Usage: a request carries raw red, green, blue and clear counts on in_data and
// is taken at a rising edge where in_valid is high and in_stall is low. Each
// request yields one result on out_data, handed over where out_valid is high and
// out_stall is low. The block takes one request every cycle while in_stall is low.
// There are eleven register stages: one input stage, one setup stage, eight
// divider stages (six restoring dividers, two quotient bits per stage) and the
// output register. out_valid is the valid bit of the output register, and the
// result is handed over from that register.
// Every stage advances when the stage after it is empty or moving, so bubbles
// are squeezed out under a stall and new requests keep entering until the
// pipeline is full; a stalled result holds steady.
// Reset clears all valid bits and loads the three thresholds with their
// defaults. The thresholds are written over the APB port at byte addresses
// 0, 4 and 8 and should change only while the pipeline is empty.
module color_hsv_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  chsv_pkg::in_t      in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output chsv_pkg::out_t     out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import chsv_pkg::*;

    localparam int NST = NDIV + 3;

    logic [15:0] blue_sat_max_reg;
    logic [15:0] blue_val_max_reg;
    logic [15:0] black_val_max_reg;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] rdy;

    s1_t  s1_reg, s1_next;
    div_t s2_reg, s2_next;
    div_t dv_reg  [NDIV];
    div_t dv_next [NDIV];
    out_t out_reg, out_next;

    // Two restoring steps in every lane of one divider stage.
    function automatic div_t div_stage(div_t src);
        div_t y;
        logic [15:0] dv;
        y = src;
        for (int l = 0; l < NLANE; l++)
        begin
            if (l == LANE_SAT)
                dv = src.mx;
            else if (l == LANE_HUE)
                dv = src.d;
            else
                dv = src.c;
            y.lane[l] = div_step(div_step(src.lane[l], dv), dv);
        end
        return y;
    endfunction

    // Register port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_sat_max_reg  <= BLUE_SAT_MAX_RST;
            blue_val_max_reg  <= BLUE_VAL_MAX_RST;
            black_val_max_reg <= BLACK_VAL_MAX_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                REG_BLUE_SAT_MAX:  blue_sat_max_reg  <= pwdata[15:0];
                REG_BLUE_VAL_MAX:  blue_val_max_reg  <= pwdata[15:0];
                REG_BLACK_VAL_MAX: black_val_max_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BLUE_SAT_MAX:  prdata = {16'd0, blue_sat_max_reg};
            REG_BLUE_VAL_MAX:  prdata = {16'd0, blue_val_max_reg};
            REG_BLACK_VAL_MAX: prdata = {16'd0, black_val_max_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Ready chain: a stage moves when it is empty or the next one moves.
    always_comb
    begin
        rdy[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage one: extremes, spread, hue numerator offset and lux products.
    always_comb
    begin
        logic [15:0] r, g, b, mx, mn;
        logic [17:0] t;
        r = in_data.red_count;
        g = in_data.green_count;
        b = in_data.blue_count;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (g < mn) mn = g;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        s1_next.c  = in_data.clear_count;
        s1_next.r  = r;
        s1_next.g  = g;
        s1_next.b  = b;
        s1_next.mx = mx;
        s1_next.d  = mx - mn;
        if (mx == r)
        begin
            s1_next.ksel = MAX_RED;
            t = {2'b0, g} + {2'b0, s1_next.d} - {2'b0, b};
        end
        else if (mx == g)
        begin
            s1_next.ksel = MAX_GREEN;
            t = {2'b0, b} + {2'b0, s1_next.d} - {2'b0, r};
        end
        else
        begin
            s1_next.ksel = MAX_BLUE;
            t = {2'b0, r} + {2'b0, s1_next.d} - {2'b0, g};
        end
        s1_next.nd = t[16:0];
        s1_next.pg = LUX_KG * {17'd0, g};
        s1_next.pr = LUX_KR * {15'd0, r};
        s1_next.pb = LUX_KB * {16'd0, b};
    end

    // Stage two: range checks, overflow flags, lux and divider setup.
    always_comb
    begin
        logic [29:0] mx10k, d10k;
        logic [28:0] hnum;
        logic signed [34:0] acc;
        mx10k = {14'd0, s1_reg.mx} * DIM_SCALE;
        d10k  = {14'd0, s1_reg.d} * DIM_SCALE;
        hnum  = {12'd0, s1_reg.nd} * HUE_SIXTH29;
        acc   = $signed({2'b0, s1_reg.pg}) - $signed({4'b0, s1_reg.pr})
              - $signed({3'b0, s1_reg.pb});
        s2_next.c    = s1_reg.c;
        s2_next.mx   = s1_reg.mx;
        s2_next.d    = s1_reg.d;
        s2_next.ksel = s1_reg.ksel;
        s2_next.hue_ok = (s1_reg.c != 16'd0) && (mx10k >= {14'd0, s1_reg.c})
                      && (d10k >= {14'd0, s1_reg.c}) && (s1_reg.d != 16'd0);
        s2_next.lux  = (acc > 35'sd0) ? acc[32:16] : 17'd0;

        // Normalization lanes: numerator count << 14.
        s2_next.lane[LANE_R]   = '{rem: {2'b0, s1_reg.r[15:2]},
                                   lo: {s1_reg.r[1:0], 14'd0}, quo: 16'd0};
        s2_next.lane[LANE_G]   = '{rem: {2'b0, s1_reg.g[15:2]},
                                   lo: {s1_reg.g[1:0], 14'd0}, quo: 16'd0};
        s2_next.lane[LANE_B]   = '{rem: {2'b0, s1_reg.b[15:2]},
                                   lo: {s1_reg.b[1:0], 14'd0}, quo: 16'd0};
        s2_next.lane[LANE_VAL] = '{rem: {2'b0, s1_reg.mx[15:2]},
                                   lo: {s1_reg.mx[1:0], 14'd0}, quo: 16'd0};
        s2_next.lane[LANE_SAT] = '{rem: s1_reg.d, lo: 16'd0, quo: 16'd0};
        s2_next.lane[LANE_HUE] = '{rem: {3'b0, hnum[28:16]}, lo: hnum[15:0],
                                   quo: 16'd0};

        // Quotients of 65536 and above saturate.
        s2_next.ovf[LANE_R]   = {2'b0, s1_reg.r}  >= {s1_reg.c, 2'b0};
        s2_next.ovf[LANE_G]   = {2'b0, s1_reg.g}  >= {s1_reg.c, 2'b0};
        s2_next.ovf[LANE_B]   = {2'b0, s1_reg.b}  >= {s1_reg.c, 2'b0};
        s2_next.ovf[LANE_VAL] = {2'b0, s1_reg.mx} >= {s1_reg.c, 2'b0};
        s2_next.ovf[LANE_SAT] = s1_reg.d == s1_reg.mx;
    end

    // Divider stages: two restoring steps per stage in every lane.
    always_comb
    begin
        dv_next[0] = div_stage(s2_reg);
        for (int s = 1; s < NDIV; s++)
        begin
            dv_next[s] = div_stage(dv_reg[s-1]);
        end
    end

    // Output stage: saturation, hue offset and classification.
    always_comb
    begin
        div_t f;
        logic        czero;
        logic [12:0] q;
        logic [14:0] h;
        f = dv_reg[NDIV-1];
        czero = f.c == 16'd0;
        out_next.red_norm   = czero ? 16'd0 : (f.ovf[LANE_R] ? 16'hFFFF
                                                             : f.lane[LANE_R].quo);
        out_next.green_norm = czero ? 16'd0 : (f.ovf[LANE_G] ? 16'hFFFF
                                                             : f.lane[LANE_G].quo);
        out_next.blue_norm  = czero ? 16'd0 : (f.ovf[LANE_B] ? 16'hFFFF
                                                             : f.lane[LANE_B].quo);
        out_next.brightness = czero ? 16'd0 : (f.ovf[LANE_VAL] ? 16'hFFFF
                                                               : f.lane[LANE_VAL].quo);
        out_next.saturation = !f.hue_ok ? 16'd0 : (f.ovf[LANE_SAT] ? 16'hFFFF
                                                                   : f.lane[LANE_SAT].quo);
        q = f.lane[LANE_HUE].quo[12:0];
        unique case (f.ksel)
            MAX_RED:   h = ({2'b0, q} < HUE_SIXTH) ? {2'b0, q} + HUE_WRAP
                                                   : {2'b0, q} - HUE_SIXTH;
            MAX_GREEN: h = {2'b0, q} + HUE_GREEN;
            MAX_BLUE:  h = {2'b0, q} + HUE_BLUE;
            default:   h = 15'd0;
        endcase
        out_next.hue = f.hue_ok ? h : 15'd0;
        out_next.lux = f.lux;
        if (out_next.saturation < blue_sat_max_reg)
            out_next.color_class = (out_next.brightness < blue_val_max_reg)
                                 ? CLASS_BLUE : CLASS_BLACK;
        else
            out_next.color_class = (out_next.brightness < black_val_max_reg)
                                 ? CLASS_BLACK : CLASS_RED;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
            s1_reg <= s1_next;
        if (rdy[1])
            s2_reg <= s2_next;
        for (int s = 0; s < NDIV; s++)
        begin
            if (rdy[s+2])
                dv_reg[s] <= dv_next[s];
        end
        if (rdy[NST-1])
            out_reg <= out_next;
    end

endmodule
